// ----- hdl/segisc_pkg.sv -----
`default_nettype none

package segisc_pkg;

  // configuration register and result code widths
  localparam int unsigned DET_TOL_W  = 35;
  localparam int unsigned PAR_TOL_W  = 16;
  localparam int unsigned CFG_DATA_W = 35;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned HIT_W      = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DET_TOL = 1'b0,
    CFG_PAR_TOL = 1'b1
  } cfg_index_e;

  // result codes
  typedef enum logic [HIT_W-1:0] {
    HIT_NONE     = 3'd0,
    HIT_INTERIOR = 3'd1,
    HIT_AT_A     = 3'd2,
    HIT_AT_B     = 3'd3,
    HIT_AT_C     = 3'd4,
    HIT_AT_D     = 3'd5
  } hit_code_e;

  // range, parallel and ray flags handed to the classify stage
  typedef struct packed {
    logic parallel;
    logic out_of_range;
    logic ray;
  } segisc_flags_t;

endpackage

`default_nettype wire

// ----- hdl/segment_intersection_classify.sv -----
// segment_intersection_classify: classifies where segment AB meets segment CD,
// or the ray from C through D when ray_mode_i is set.
// Input channel: in_valid_i / in_stall_o carry the eight coordinates and the
// mode flag; a transaction completes when valid is high and stall is low.
// Output channel: out_valid_o / out_stall_i carry hit_code_o (0 none,
// 1 interior, 2 at A, 3 at B, 4 at C, 5 at D).
// Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i
// (0 determinant tolerance, 1 parameter tolerance with FRAC_BITS fraction
// bits); write only while no transaction is in flight.
// Throughput is one transaction per cycle while out_stall_i is low, since each
// of the six register stages (differences, products, determinant and
// numerators, sign fold, range tests with the tolerance product, endpoint
// compares) takes a new item every cycle unless held by a stall.
// Reset clears all stage valid bits and loads both tolerances with 1.
// A stalled result holds; each stage still takes data while it or a later
// stage has a free slot, so bubbles close up under a stall.
`default_nettype none

module segment_intersection_classify #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    cfg_we_i,
  input  wire logic [segisc_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [segisc_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  wire logic                                    in_valid_i,
  output logic                                         in_stall_o,
  input  wire logic signed [COORD_BITS-1:0]            ax_i,
  input  wire logic signed [COORD_BITS-1:0]            ay_i,
  input  wire logic signed [COORD_BITS-1:0]            bx_i,
  input  wire logic signed [COORD_BITS-1:0]            by_coord_i,
  input  wire logic signed [COORD_BITS-1:0]            cx_i,
  input  wire logic signed [COORD_BITS-1:0]            cy_i,
  input  wire logic signed [COORD_BITS-1:0]            dx_i,
  input  wire logic signed [COORD_BITS-1:0]            dy_i,
  input  wire logic                                    ray_mode_i,
  output logic                                         out_valid_o,
  input  wire logic                                    out_stall_i,
  output logic [segisc_pkg::HIT_W-1:0]                 hit_code_o
);

  localparam int unsigned NS    = 6;
  localparam int unsigned DW    = COORD_BITS + 1;
  localparam int unsigned PW    = 2 * COORD_BITS + 2;
  localparam int unsigned WW    = 2 * COORD_BITS + 3;
  localparam int unsigned MAG_W = 2 * COORD_BITS + 2;
  localparam int unsigned TDW   = MAG_W + segisc_pkg::PAR_TOL_W;
  localparam int unsigned TCW   = (WW > segisc_pkg::DET_TOL_W) ? WW : segisc_pkg::DET_TOL_W;

  // configuration registers
  logic [segisc_pkg::DET_TOL_W-1:0] det_tol_q;
  logic [segisc_pkg::PAR_TOL_W-1:0] par_tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      det_tol_q <= segisc_pkg::DET_TOL_W'(1);
      par_tol_q <= segisc_pkg::PAR_TOL_W'(1);
    end else if (cfg_we_i) begin
      unique case (segisc_pkg::cfg_index_e'(cfg_index_i))
        segisc_pkg::CFG_DET_TOL: det_tol_q <= cfg_data_i[segisc_pkg::DET_TOL_W-1:0];
        segisc_pkg::CFG_PAR_TOL: par_tol_q <= cfg_data_i[segisc_pkg::PAR_TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // stage valid bits and ready chain
  logic [NS-1:0] vld_q;
  logic [NS-1:0] vld_d;
  logic [NS-1:0] rdy;

  always_comb begin
    rdy[NS-1] = !vld_q[NS-1] || !out_stall_i;
    for (int k = NS - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (rdy[0]) vld_d[0] = in_valid_i;
    for (int k = 1; k < NS; k++) begin
      if (rdy[k]) vld_d[k] = vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_stall_o  = !rdy[0];
  assign out_valid_o = vld_q[NS-1];

  // stage 1: edge vectors
  logic signed [DW-1:0] abx_q, aby_q, acx_q, acy_q, cdx_q, cdy_q;
  logic                 ray1_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      abx_q  <= DW'(bx_i) - DW'(ax_i);
      aby_q  <= DW'(by_coord_i) - DW'(ay_i);
      acx_q  <= DW'(cx_i) - DW'(ax_i);
      acy_q  <= DW'(cy_i) - DW'(ay_i);
      cdx_q  <= DW'(dx_i) - DW'(cx_i);
      cdy_q  <= DW'(dy_i) - DW'(cy_i);
      ray1_q <= ray_mode_i;
    end
  end

  // stage 2: cross products
  logic signed [PW-1:0] p_cdx_aby_q, p_abx_cdy_q, p_cdx_acy_q;
  logic signed [PW-1:0] p_cdy_acx_q, p_abx_acy_q, p_aby_acx_q;
  logic                 ray2_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      p_cdx_aby_q <= cdx_q * aby_q;
      p_abx_cdy_q <= abx_q * cdy_q;
      p_cdx_acy_q <= cdx_q * acy_q;
      p_cdy_acx_q <= cdy_q * acx_q;
      p_abx_acy_q <= abx_q * acy_q;
      p_aby_acx_q <= aby_q * acx_q;
      ray2_q      <= ray1_q;
    end
  end

  // stage 3: determinant and numerators
  logic signed [WW-1:0] det_q, nt_q, nu_q;
  logic                 ray3_q;

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      det_q  <= WW'(p_cdx_aby_q) - WW'(p_abx_cdy_q);
      nt_q   <= WW'(p_cdx_acy_q) - WW'(p_cdy_acx_q);
      nu_q   <= WW'(p_abx_acy_q) - WW'(p_aby_acx_q);
      ray3_q <= ray2_q;
    end
  end

  // stage 4: fold sign so the determinant is nonnegative
  logic signed [WW-1:0] det_abs_q, ntn_q, nun_q;
  logic                 ray4_q;

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      if (det_q[WW-1]) begin
        det_abs_q <= -det_q;
        ntn_q     <= -nt_q;
        nun_q     <= -nu_q;
      end else begin
        det_abs_q <= det_q;
        ntn_q     <= nt_q;
        nun_q     <= nu_q;
      end
      ray4_q <= ray3_q;
    end
  end

  // stage 5: range tests, endpoint distances, tolerance times determinant
  logic [TCW-1:0]        det_ext;
  logic [TCW-1:0]        det_tol_ext;
  logic signed [WW-1:0]  det_minus_nt;
  logic signed [WW-1:0]  det_minus_nu;
  segisc_pkg::segisc_flags_t flags_d;

  assign det_ext      = TCW'(unsigned'(det_abs_q));
  assign det_tol_ext  = TCW'(det_tol_q);
  assign det_minus_nt = det_abs_q - ntn_q;
  assign det_minus_nu = det_abs_q - nun_q;

  always_comb begin
    flags_d.parallel     = (det_abs_q == '0) || (det_ext < det_tol_ext);
    flags_d.out_of_range = ntn_q[WW-1] || (ntn_q > det_abs_q) || nun_q[WW-1]
                           || (!ray4_q && (nun_q > det_abs_q));
    flags_d.ray          = ray4_q;
  end

  logic [MAG_W-1:0]          mag_t0_q, mag_t1_q, mag_u0_q, mag_u1_q;
  logic [TDW-1:0]            tol_det_q;
  segisc_pkg::segisc_flags_t flags_q;

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      mag_t0_q  <= ntn_q[MAG_W-1:0];
      mag_t1_q  <= det_minus_nt[MAG_W-1:0];
      mag_u0_q  <= nun_q[MAG_W-1:0];
      mag_u1_q  <= det_minus_nu[MAG_W-1:0];
      tol_det_q <= TDW'(par_tol_q) * TDW'(det_abs_q[MAG_W-1:0]);
      flags_q   <= flags_d;
    end
  end

  // stage 6: endpoint compares and result register
  segisc_pkg::hit_code_e hit_code_d;
  logic [segisc_pkg::HIT_W-1:0] hit_code_q;

  segisc_classify #(
    .MAG_W     (MAG_W),
    .FRAC_BITS (FRAC_BITS)
  ) u_classify (
    .mag_t0_i   (mag_t0_q),
    .mag_t1_i   (mag_t1_q),
    .mag_u0_i   (mag_u0_q),
    .mag_u1_i   (mag_u1_q),
    .tol_det_i  (tol_det_q),
    .flags_i    (flags_q),
    .hit_code_o (hit_code_d)
  );

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      hit_code_q <= hit_code_d;
    end
  end

  assign hit_code_o = hit_code_q;

endmodule

`default_nettype wire

// ----- hdl/segisc_classify.sv -----
`default_nettype none

module segisc_classify #(
  parameter int unsigned MAG_W     = 34,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic [MAG_W-1:0]                        mag_t0_i,
  input  wire logic [MAG_W-1:0]                        mag_t1_i,
  input  wire logic [MAG_W-1:0]                        mag_u0_i,
  input  wire logic [MAG_W-1:0]                        mag_u1_i,
  input  wire logic [MAG_W+segisc_pkg::PAR_TOL_W-1:0]  tol_det_i,
  input  wire segisc_pkg::segisc_flags_t               flags_i,
  output segisc_pkg::hit_code_e                        hit_code_o
);

  localparam int unsigned CMP_W = MAG_W + FRAC_BITS + segisc_pkg::PAR_TOL_W;

  logic [CMP_W-1:0] rhs;
  logic             near_t0;
  logic             near_t1;
  logic             near_u0;
  logic             near_u1;

  // mag * 2^frac < tol * det, exact
  assign rhs     = CMP_W'(tol_det_i);
  assign near_t0 = CMP_W'({mag_t0_i, {FRAC_BITS{1'b0}}}) < rhs;
  assign near_t1 = CMP_W'({mag_t1_i, {FRAC_BITS{1'b0}}}) < rhs;
  assign near_u0 = CMP_W'({mag_u0_i, {FRAC_BITS{1'b0}}}) < rhs;
  assign near_u1 = CMP_W'({mag_u1_i, {FRAC_BITS{1'b0}}}) < rhs;

  // priority of endpoint tests
  always_comb begin
    if (flags_i.parallel || flags_i.out_of_range) begin
      hit_code_o = segisc_pkg::HIT_NONE;
    end else if (near_t0) begin
      hit_code_o = segisc_pkg::HIT_AT_A;
    end else if (near_t1) begin
      hit_code_o = segisc_pkg::HIT_AT_B;
    end else if (near_u0) begin
      hit_code_o = segisc_pkg::HIT_AT_C;
    end else if (!flags_i.ray && near_u1) begin
      hit_code_o = segisc_pkg::HIT_AT_D;
    end else begin
      hit_code_o = segisc_pkg::HIT_INTERIOR;
    end
  end

endmodule

`default_nettype wire
